FILE: src/vgf_pkg.sv
// ----------------------------------------------------------------------------
// vgf_pkg
// Shared constants, codes and control types of the voxel grid point filter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package vgf_pkg;

	// grid geometry
	localparam int GRID_SIDE = 32;
	localparam int CRD_W     = $clog2(GRID_SIDE);
	localparam int MAP_DEPTH = GRID_SIDE * GRID_SIDE * GRID_SIDE;
	localparam int IDX_W     = $clog2(MAP_DEPTH);
	localparam int PRD_W     = 3 * CRD_W;
	localparam int SUM_W     = PRD_W + 1;

	// visited store: rows of bits, one valid flop per row
	localparam int ROW_AW   = (IDX_W > 8) ? 8 : IDX_W - 1;
	localparam int ROW_BW   = IDX_W - ROW_AW;
	localparam int ROWS     = 2 ** ROW_AW;
	localparam int ROW_BITS = 2 ** ROW_BW;

	// configuration registers
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_INV_LEAF   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BOUND_LOW  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BOUND_HIGH = 2'd2;

	localparam logic [31:0] INV_LEAF_RST   = 32'd65536;
	localparam logic [31:0] BOUND_LOW_RST  = 32'hFFF1_0000;
	localparam logic [31:0] BOUND_HIGH_RST = 32'h000F_0000;

	// operand of the shared multiplier
	typedef enum logic [2:0] {
		OP_LO = 3'd0,
		OP_HI = 3'd1,
		OP_X  = 3'd2,
		OP_Y  = 3'd3,
		OP_Z  = 3'd4
	} op_t;

	typedef struct packed {
		logic load;
		logic mul_en;
		op_t  mul_op;
		logic cap_en;
		op_t  cap_op;
		logic chk_en;
		logic idx1_en;
		logic idx2_en;
		logic rd_en;
		logic wr_en;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic pass;
		logic inrng;
		logic hit;
		logic out_busy;
	} sts_t;

endpackage

`default_nettype wire

FILE: src/vgf_ctrl.sv
// ----------------------------------------------------------------------------
// vgf_ctrl
// Sequencer of the filter: steps one point through multiply, check, index,
// store lookup and output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vgf_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire vgf_pkg::sts_t sts,
	output vgf_pkg::cmd_t      cmd
);
	import vgf_pkg::*;

	typedef enum logic [12:0] {
		S_IDLE = 13'b0000000000001,
		S_MLO  = 13'b0000000000010,
		S_MHI  = 13'b0000000000100,
		S_MX   = 13'b0000000001000,
		S_MY   = 13'b0000000010000,
		S_MZ   = 13'b0000000100000,
		S_MCAP = 13'b0000001000000,
		S_CHK  = 13'b0000010000000,
		S_IDX1 = 13'b0000100000000,
		S_IDX2 = 13'b0001000000000,
		S_RD   = 13'b0010000000000,
		S_WR   = 13'b0100000000000,
		S_OUT  = 13'b1000000000000
	} state_t;

	state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load  = 1'b1;
					state_nxt = S_MLO;
				end
			end
			S_MLO: begin
				cmd.mul_en = 1'b1;
				cmd.mul_op = OP_LO;
				state_nxt  = S_MHI;
			end
			S_MHI: begin
				cmd.mul_en = 1'b1;
				cmd.mul_op = OP_HI;
				cmd.cap_en = 1'b1;
				cmd.cap_op = OP_LO;
				state_nxt  = S_MX;
			end
			S_MX: begin
				cmd.mul_en = 1'b1;
				cmd.mul_op = OP_X;
				cmd.cap_en = 1'b1;
				cmd.cap_op = OP_HI;
				state_nxt  = S_MY;
			end
			S_MY: begin
				cmd.mul_en = 1'b1;
				cmd.mul_op = OP_Y;
				cmd.cap_en = 1'b1;
				cmd.cap_op = OP_X;
				state_nxt  = S_MZ;
			end
			S_MZ: begin
				cmd.mul_en = 1'b1;
				cmd.mul_op = OP_Z;
				cmd.cap_en = 1'b1;
				cmd.cap_op = OP_Y;
				state_nxt  = S_MCAP;
			end
			S_MCAP: begin
				cmd.cap_en = 1'b1;
				cmd.cap_op = OP_Z;
				state_nxt  = S_CHK;
			end
			S_CHK: begin
				cmd.chk_en = 1'b1;
				state_nxt  = S_IDX1;
			end
			S_IDX1: begin
				cmd.idx1_en = 1'b1;
				// oversized grid forwards every point, in range or not
				if (sts.pass) begin
					state_nxt = S_OUT;
				end else if (!sts.inrng) begin
					state_nxt = S_IDLE;
				end else begin
					state_nxt = S_IDX2;
				end
			end
			S_IDX2: begin
				cmd.idx2_en = 1'b1;
				state_nxt   = S_RD;
			end
			S_RD: begin
				cmd.rd_en = 1'b1;
				state_nxt = S_WR;
			end
			S_WR: begin
				if (sts.hit) begin
					state_nxt = S_IDLE;
				end else begin
					cmd.wr_en = 1'b1;
					state_nxt = S_OUT;
				end
			end
			S_OUT: begin
				if (!sts.out_busy) begin
					cmd.out_load = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

FILE: src/vgf_datapath.sv
// ----------------------------------------------------------------------------
// vgf_datapath
// Configuration registers, shared voxel multiplier, limit checks, voxel index
// arithmetic, visited store and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vgf_datapath (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_valid,
	input  wire logic [vgf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [31:0]                    cfg_data,
	input  wire logic                           cloud_start,
	input  wire logic signed [31:0]             px,
	input  wire logic signed [31:0]             py,
	input  wire logic signed [31:0]             pz,
	input  wire logic                           out_ready,
	input  wire vgf_pkg::cmd_t                  cmd,
	output vgf_pkg::sts_t                       sts,
	output logic                                out_valid,
	output logic signed [31:0]                  out_x,
	output logic signed [31:0]                  out_y,
	output logic signed [31:0]                  out_z,
	output logic                                passthrough
);
	import vgf_pkg::*;

	logic        [31:0] inv_leaf_q;
	logic signed [31:0] bound_low_q;
	logic signed [31:0] bound_high_q;

	logic signed [31:0] px_q, py_q, pz_q;
	logic signed [31:0] mul_a;
	logic signed [64:0] mul_full;
	logic        [63:0] prod_q;
	logic signed [31:0] vox;
	logic signed [31:0] lo_q, hi_q, vx_q, vy_q, vz_q;

	logic signed [32:0] side_q;
	logic               inrng_q;
	logic               pass;
	logic        [31:0] dx, dy, dz;
	logic [CRD_W-1:0]   cx_q, cy_q, cz_q;
	logic [CRD_W-1:0]   side_w;
	logic [2*CRD_W-1:0] s2_q, t1_q;
	logic [SUM_W-1:0]   idx_sum;
	logic [IDX_W-1:0]   idx_q;

	logic [ROW_BITS-1:0] mem [ROWS];
	logic [ROWS-1:0]     row_vld_q;
	logic [ROW_BITS-1:0] rd_row_q;
	logic                rd_vld_q;
	logic [ROW_AW-1:0]   row_addr;
	logic [ROW_BW-1:0]   bit_sel;
	logic [ROW_BITS-1:0] wr_row;

	logic out_valid_q;
	logic out_pass_q;
	logic signed [31:0] out_x_q, out_y_q, out_z_q;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_leaf_q   <= INV_LEAF_RST;
			bound_low_q  <= BOUND_LOW_RST;
			bound_high_q <= BOUND_HIGH_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_INV_LEAF:   inv_leaf_q   <= cfg_data;
				REG_BOUND_LOW:  bound_low_q  <= cfg_data;
				REG_BOUND_HIGH: bound_high_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// shared multiplier: signed coordinate times unsigned reciprocal
	always_comb begin
		case (cmd.mul_op)
			OP_LO:   mul_a = bound_low_q;
			OP_HI:   mul_a = bound_high_q;
			OP_X:    mul_a = px_q;
			OP_Y:    mul_a = py_q;
			OP_Z:    mul_a = pz_q;
			default: mul_a = px_q;
		endcase
	end

	assign mul_full = mul_a * $signed({1'b0, inv_leaf_q});
	// arithmetic shift of the exact product is the floor
	assign vox      = $signed(prod_q[63:32]);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			px_q <= px;
			py_q <= py;
			pz_q <= pz;
		end
		if (cmd.mul_en) begin
			prod_q <= mul_full[63:0];
		end
		if (cmd.cap_en) begin
			case (cmd.cap_op)
				OP_LO:   lo_q <= vox;
				OP_HI:   hi_q <= vox;
				OP_X:    vx_q <= vox;
				OP_Y:    vy_q <= vox;
				OP_Z:    vz_q <= vox;
				default: ;
			endcase
		end
	end

	// limit check and grid coordinates
	assign dx = vx_q - lo_q;
	assign dy = vy_q - lo_q;
	assign dz = vz_q - lo_q;

	always_ff @(posedge clk) begin
		if (cmd.chk_en) begin
			side_q  <= {hi_q[31], hi_q} - {lo_q[31], lo_q};
			inrng_q <= (px_q > bound_low_q) && (px_q < bound_high_q) &&
			           (py_q > bound_low_q) && (py_q < bound_high_q) &&
			           (pz_q > bound_low_q) && (pz_q < bound_high_q);
			cx_q    <= dx[CRD_W-1:0];
			cy_q    <= dy[CRD_W-1:0];
			cz_q    <= dz[CRD_W-1:0];
		end
	end

	assign pass   = (side_q >= $signed(33'(GRID_SIDE)));
	// only used when in range and not oversized, so side fits the coord width
	assign side_w = side_q[CRD_W-1:0];

	assign idx_sum = SUM_W'(cx_q) + SUM_W'(t1_q) + SUM_W'(cz_q) * SUM_W'(s2_q);

	always_ff @(posedge clk) begin
		if (cmd.idx1_en) begin
			s2_q <= (2*CRD_W)'(side_w) * (2*CRD_W)'(side_w);
			t1_q <= (2*CRD_W)'(cy_q) * (2*CRD_W)'(side_w);
		end
		if (cmd.idx2_en) begin
			idx_q <= idx_sum[IDX_W-1:0];
		end
	end

	// visited store, read-modify-write of one row
	assign row_addr = idx_q[IDX_W-1:ROW_BW];
	assign bit_sel  = idx_q[ROW_BW-1:0];
	assign wr_row   = (rd_vld_q ? rd_row_q : '0) | (ROW_BITS'(1) << bit_sel);

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rd_row_q <= mem[row_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[row_addr] <= wr_row;
		end
	end

	// a row never written in this cloud reads as all clear
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
			rd_vld_q  <= 1'b0;
		end else begin
			if (cmd.load && cloud_start) begin
				row_vld_q <= '0;
			end else if (cmd.wr_en) begin
				row_vld_q[row_addr] <= 1'b1;
			end
			if (cmd.rd_en) begin
				rd_vld_q <= row_vld_q[row_addr];
			end
		end
	end

	// output word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_x_q    <= px_q;
			out_y_q    <= py_q;
			out_z_q    <= pz_q;
			out_pass_q <= pass;
		end
	end

	assign sts.pass     = pass;
	assign sts.inrng    = inrng_q;
	assign sts.hit      = rd_vld_q && rd_row_q[bit_sel];
	assign sts.out_busy = out_valid_q && !out_ready;

	assign out_valid   = out_valid_q;
	assign out_x       = out_x_q;
	assign out_y       = out_y_q;
	assign out_z       = out_z_q;
	assign passthrough = out_pass_q;

endmodule

`default_nettype wire

FILE: src/voxel_grid_first_point_filter.sv
// ----------------------------------------------------------------------------
// voxel_grid_first_point_filter
// Keeps the first point of each occupied voxel of a cloud, in arrival order.
// ----------------------------------------------------------------------------
// A point is taken only while the block is idle. The single shared 33 by 32
// bit multiplier forms the two limit voxels and the three point voxels one
// after another. When the grid is oversized every point then passes through
// flagged; else a point at or outside a limit is dropped, and the index
// arithmetic and a read-modify-write of one row of the visited store follow
// for the rest, dropping a point whose voxel was already visited. A point
// that goes out is loaded into the output register once that is free and
// waits there, so the next point is accepted without waiting for it. The
// visited store has one valid flop per row; cloud_start clears them in the
// cycle its point is accepted, so there is no clearing pass. Configuration
// writes are taken in any cycle and must only be issued while the block is
// idle.
`timescale 1ns / 1ps
`default_nettype none

module voxel_grid_first_point_filter (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [vgf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [31:0]                    cfg_data,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic                           cloud_start,
	input  wire logic signed [31:0]             px,
	input  wire logic signed [31:0]             py,
	input  wire logic signed [31:0]             pz,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic signed [31:0]                  out_x,
	output logic signed [31:0]                  out_y,
	output logic signed [31:0]                  out_z,
	output logic                                passthrough
);
	import vgf_pkg::*;

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	vgf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	vgf_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.cloud_start (cloud_start),
		.px          (px),
		.py          (py),
		.pz          (pz),
		.out_ready   (out_ready),
		.cmd         (cmd),
		.sts         (sts),
		.out_valid   (out_valid),
		.out_x       (out_x),
		.out_y       (out_y),
		.out_z       (out_z),
		.passthrough (passthrough)
	);

endmodule

`default_nettype wire

FILE: src/vgf_checker.sv
// ----------------------------------------------------------------------------
// vgf_checker
// Port level checks of the voxel grid point filter, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vgf_checker (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           cfg_valid,
	input wire logic                           cfg_ready,
	input wire logic [vgf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input wire logic [31:0]                    cfg_data,
	input wire logic                           in_valid,
	input wire logic                           in_ready,
	input wire logic                           cloud_start,
	input wire logic signed [31:0]             px,
	input wire logic signed [31:0]             py,
	input wire logic signed [31:0]             pz,
	input wire logic                           out_valid,
	input wire logic                           out_ready,
	input wire logic signed [31:0]             out_x,
	input wire logic signed [31:0]             out_y,
	input wire logic signed [31:0]             out_z,
	input wire logic                           passthrough
);

	// a stalled output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=>
			out_valid && $stable(out_x) && $stable(out_y) && $stable(out_z) &&
			$stable(passthrough))
		else $error("output word changed while stalled");

	// one point at a time: busy right after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted twice in a row");

	// no word can come out of the cycle that follows an accept
	a_no_early_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !$rose(out_valid))
		else $error("output word appeared right after accept");

	// a new word is only produced while a point is being worked on
	a_out_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("output word appeared while idle");

endmodule

bind voxel_grid_first_point_filter vgf_checker u_vgf_checker (.*);

`default_nettype wire
